// ===== hdl/rte_pkg.sv =====
// Shared constants and types for the route table engine.
package rte_pkg;

    localparam int unsigned DEF_TABLE_ENTRIES  = 16;
    localparam logic [31:0] DEF_LIFETIME       = 32'd30000;

    localparam logic [2:0] ACT_LOOKUP     = 3'd0;
    localparam logic [2:0] ACT_ADD        = 3'd1;
    localparam logic [2:0] ACT_REFRESH    = 3'd2;
    localparam logic [2:0] ACT_INVALIDATE = 3'd3;
    localparam logic [2:0] ACT_SWEEP      = 3'd4;

    localparam logic [3:0] ST_MISS        = 4'd0;
    localparam logic [3:0] ST_HIT         = 4'd1;
    localparam logic [3:0] ST_UPDATED     = 4'd2;
    localparam logic [3:0] ST_UNCHANGED   = 4'd3;
    localparam logic [3:0] ST_INSERTED    = 4'd4;
    localparam logic [3:0] ST_FULL        = 4'd5;
    localparam logic [3:0] ST_REFRESHED   = 4'd6;
    localparam logic [3:0] ST_INVALIDATED = 4'd7;
    localparam logic [3:0] ST_SWEPT       = 4'd8;

    typedef struct packed {
        logic [7:0]  dest;
        logic [7:0]  nhop;
        logic [7:0]  hops;
        logic [31:0] seq;
        logic [31:0] expiry;
    } entry_t;

endpackage

// ===== hdl/rte_entry_mem.sv =====
// Route entry storage: one write port, one registered read port.
module rte_entry_mem #(
    parameter int unsigned DEPTH  = rte_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  rte_pkg::entry_t     wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output rte_pkg::entry_t     rdata
);

    rte_pkg::entry_t mem [DEPTH];
    rte_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/route_table_engine_core.sv =====
// Route table engine: sequential scan over the entry memory for each item; the scan
// stops at the first slot that ends it or runs over all TABLE_ENTRIES slots, and an
// add that finds no live match then passes through an insert state; unknown action
// codes skip the scan and go straight to the result state.
// Throughput: one item at a time, next accept the cycle after the result loads.
// Reset clears all valid bits and loads the lifetime register with 30000.
module route_table_engine_core #(
    parameter int unsigned TABLE_ENTRIES = rte_pkg::DEF_TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [31:0] now,
    input  logic [7:0]  dest_node,
    input  logic [7:0]  via_node,
    input  logic [7:0]  hops,
    input  logic [31:0] dest_seq,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [7:0]  route_next_hop,
    output logic [7:0]  route_hops,
    output logic [31:0] route_seq
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_INSERT, S_DONE} state_t;

    state_t               state_reg;
    logic [31:0]          lifetime_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [2:0]           act_reg;
    logic [31:0]          now_reg;
    logic [7:0]           dest_reg;
    logic [7:0]           via_reg;
    logic [7:0]           hops_reg;
    logic [31:0]          seq_reg;
    logic [31:0]          exp_reg;

    logic [CNT_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic                 eval_vld_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;

    logic [3:0]           res_status_reg;
    logic [7:0]           res_hop_reg;
    logic [7:0]           res_hops_reg;
    logic [31:0]          res_seq_reg;

    logic                 out_valid_reg;
    logic [3:0]           status_reg;
    logic [7:0]           nhop_out_reg;
    logic [7:0]           hops_out_reg;
    logic [31:0]          seq_out_reg;

    rte_pkg::entry_t      rd_data;
    rte_pkg::entry_t      mem_wdata;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [IDX_W-1:0]     rd_addr;

    logic                 issue_ok;
    logic                 last_eval;
    logic                 search_act;
    logic                 cur_v;
    logic                 cur_m;
    logic                 cur_live;
    logic [31:0]          seq_diff;
    logic                 better;
    logic                 hit;
    logic                 inv_hit;

    rte_entry_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign issue_ok   = (scan_idx_reg < CNT_W'(TABLE_ENTRIES));
    assign rd_addr    = issue_ok ? scan_idx_reg[IDX_W-1:0] : '0;
    assign last_eval  = eval_vld_reg && (eval_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign search_act = (act_reg == rte_pkg::ACT_LOOKUP) || (act_reg == rte_pkg::ACT_ADD)
                        || (act_reg == rte_pkg::ACT_REFRESH);

    // shared compare unit on the entry under evaluation
    assign cur_v    = valid_reg[eval_idx_reg];
    assign cur_m    = (rd_data.dest == dest_reg);
    assign cur_live = (rd_data.expiry > now_reg);
    assign seq_diff = seq_reg - rd_data.seq;
    // rollover compare: newer when difference is in 1 .. 2^31-1
    assign better   = ((seq_diff != 32'd0) && !seq_diff[31])
                      || ((seq_diff == 32'd0) && (hops_reg < rd_data.hops));
    assign hit      = (state_reg == S_SCAN) && eval_vld_reg && search_act
                      && cur_v && cur_m && cur_live;
    assign inv_hit  = eval_vld_reg && (act_reg == rte_pkg::ACT_INVALIDATE)
                      && cur_v && cur_m;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = eval_idx_reg;
        mem_wdata = rd_data;
        if (hit && (act_reg == rte_pkg::ACT_ADD) && better)
        begin
            mem_we    = 1'b1;
            mem_wdata = '{dest: rd_data.dest, nhop: via_reg, hops: hops_reg,
                          seq: seq_reg, expiry: exp_reg};
        end
        else if (hit && (act_reg == rte_pkg::ACT_REFRESH))
        begin
            mem_we           = 1'b1;
            mem_wdata.expiry = exp_reg;
        end
        else if ((state_reg == S_INSERT) && free_found_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = free_idx_reg;
            mem_wdata = '{dest: dest_reg, nhop: via_reg, hops: hops_reg,
                          seq: seq_reg, expiry: exp_reg};
        end
    end

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign route_next_hop = nhop_out_reg;
    assign route_hops     = hops_out_reg;
    assign route_seq      = seq_out_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg  <= action;
            now_reg  <= now;
            dest_reg <= dest_node;
            via_reg  <= via_node;
            hops_reg <= hops;
            seq_reg  <= dest_seq;
            exp_reg  <= now + lifetime_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lifetime_reg   <= rte_pkg::DEF_LIFETIME;
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            eval_idx_reg   <= '0;
            eval_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            res_status_reg <= rte_pkg::ST_MISS;
            res_hop_reg    <= '0;
            res_hops_reg   <= '0;
            res_seq_reg    <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= rte_pkg::ST_MISS;
            nhop_out_reg   <= '0;
            hops_out_reg   <= '0;
            seq_out_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                lifetime_reg <= cfg_data;
            end

            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        scan_idx_reg   <= '0;
                        eval_vld_reg   <= 1'b0;
                        free_found_reg <= 1'b0;
                        res_hop_reg    <= '0;
                        res_hops_reg   <= '0;
                        res_seq_reg    <= '0;
                        res_status_reg <= (action == rte_pkg::ACT_SWEEP) ?
                                          rte_pkg::ST_SWEPT : rte_pkg::ST_MISS;
                        if (action > rte_pkg::ACT_SWEEP)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    eval_vld_reg <= issue_ok;
                    eval_idx_reg <= rd_addr;
                    if (issue_ok)
                    begin
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                    end

                    if (last_eval && !hit && !inv_hit)
                    begin
                        state_reg <= (act_reg == rte_pkg::ACT_ADD) ? S_INSERT : S_DONE;
                    end

                    if (eval_vld_reg)
                    begin
                        if (search_act)
                        begin
                            if (cur_v && cur_m && cur_live)
                            begin
                                state_reg <= S_DONE;
                                case (act_reg)
                                    rte_pkg::ACT_LOOKUP:
                                    begin
                                        res_status_reg <= rte_pkg::ST_HIT;
                                        res_hop_reg    <= rd_data.nhop;
                                        res_hops_reg   <= rd_data.hops;
                                        res_seq_reg    <= rd_data.seq;
                                    end
                                    rte_pkg::ACT_ADD:
                                    begin
                                        res_status_reg <= better ? rte_pkg::ST_UPDATED
                                                                 : rte_pkg::ST_UNCHANGED;
                                    end
                                    default:
                                    begin
                                        res_status_reg <= rte_pkg::ST_REFRESHED;
                                    end
                                endcase
                            end
                            else if (cur_v && cur_m)
                            begin
                                valid_reg[eval_idx_reg] <= 1'b0;
                            end
                            // first slot that is free once expired matches are dropped
                            if (!free_found_reg && (!cur_v || (cur_m && !cur_live)))
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= eval_idx_reg;
                            end
                        end
                        else if (act_reg == rte_pkg::ACT_INVALIDATE)
                        begin
                            if (cur_v && cur_m)
                            begin
                                valid_reg[eval_idx_reg] <= 1'b0;
                                res_status_reg          <= rte_pkg::ST_INVALIDATED;
                                state_reg               <= S_DONE;
                            end
                        end
                        else
                        begin
                            if (cur_v && !cur_live)
                            begin
                                valid_reg[eval_idx_reg] <= 1'b0;
                            end
                        end
                    end
                end

                S_INSERT:
                begin
                    if (free_found_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        res_status_reg          <= rte_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        res_status_reg <= rte_pkg::ST_FULL;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        nhop_out_reg  <= res_hop_reg;
                        hops_out_reg  <= res_hops_reg;
                        seq_out_reg   <= res_seq_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for route_table_engine_core: directed table, then randomized phases.
module tb;

    localparam int TABLE_DEPTH  = rte_pkg::DEF_TABLE_ENTRIES;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CALM_ITEMS   = 300;
    localparam int SHOW_LIMIT   = 10;

    // codes the block treats as no-ops
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now;
        logic [7:0]  dest;
        logic [7:0]  via;
        logic [7:0]  hops;
        logic [31:0] seq;
    } route_req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  nhop;
        logic [7:0]  hops;
        logic [31:0] seq;
    } route_resp_t;

    typedef struct packed {
        route_req_t  req;
        logic        typed;
        route_resp_t resp;
    } dir_row_t;

    typedef struct {
        logic        wr;
        logic [31:0] life;
        logic [31:0] start_tick;
        int          pool;
        int          step;
        int          count;
    } phase_t;

    localparam route_resp_t NO_RESP = '0;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [31:0] now;
    logic [7:0]  dest_node;
    logic [7:0]  via_node;
    logic [7:0]  hops;
    logic [31:0] dest_seq;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  status;
    logic [7:0]  route_next_hop;
    logic [7:0]  route_hops;
    logic [31:0] route_seq;

    // predictor state
    rte_pkg::entry_t tbl_entry [TABLE_DEPTH];
    logic        tbl_used [TABLE_DEPTH];
    logic [31:0] lifetime_m;
    logic [31:0] seq_hint [256];
    logic [31:0] tick;

    route_resp_t route_answers_q [$];
    int          fault_count = 0;
    int          quiet_cycles = 0;
    int          hold_left = 0;
    logic        calm = 1'b0;
    route_resp_t got_resp;
    route_resp_t want_resp;

    dir_row_t dir_rows [26] = '{
        '{'{rte_pkg::ACT_LOOKUP, 32'd100, 8'd7, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_MISS, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_ADD, 32'd100, 8'd7, 8'd3, 8'd2, 32'd10}, 1'b1,
          '{rte_pkg::ST_INSERTED, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_LOOKUP, 32'd200, 8'd7, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_HIT, 8'd3, 8'd2, 32'd10}},
        // equal sequence, more hops
        '{'{rte_pkg::ACT_ADD, 32'd200, 8'd7, 8'd9, 8'd5, 32'd10}, 1'b1,
          '{rte_pkg::ST_UNCHANGED, 8'd0, 8'd0, 32'd0}},
        // equal sequence, fewer hops
        '{'{rte_pkg::ACT_ADD, 32'd200, 8'd7, 8'd9, 8'd1, 32'd10}, 1'b1,
          '{rte_pkg::ST_UPDATED, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_ADD, 32'd210, 8'd7, 8'd4, 8'd0, 32'd9}, 1'b1,
          '{rte_pkg::ST_UNCHANGED, 8'd0, 8'd0, 32'd0}},
        // distance of exactly half the sequence space is not newer
        '{'{rte_pkg::ACT_ADD, 32'd220, 8'd7, 8'd4, 8'd0, 32'h8000_000A}, 1'b1,
          '{rte_pkg::ST_UNCHANGED, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_ADD, 32'd230, 8'd7, 8'd4, 8'd0, 32'h8000_0009}, 1'b1,
          '{rte_pkg::ST_UPDATED, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_LOOKUP, 32'd240, 8'd7, 8'd0, 8'd0, 32'd0}, 1'b0, NO_RESP},
        '{'{rte_pkg::ACT_REFRESH, 32'd300, 8'd7, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_REFRESHED, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_REFRESH, 32'd300, 8'd8, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_MISS, 8'd0, 8'd0, 32'd0}},
        '{'{ACT_SPARE_5, 32'd300, 8'd7, 8'd1, 8'd1, 32'd1}, 1'b1,
          '{rte_pkg::ST_MISS, 8'd0, 8'd0, 32'd0}},
        '{'{ACT_SPARE_6, 32'd300, 8'd7, 8'd1, 8'd1, 32'd1}, 1'b1,
          '{rte_pkg::ST_MISS, 8'd0, 8'd0, 32'd0}},
        '{'{ACT_SPARE_7, 32'd300, 8'd7, 8'd1, 8'd1, 32'd1}, 1'b1,
          '{rte_pkg::ST_MISS, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_ADD, 32'd400, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
          '{rte_pkg::ST_INSERTED, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_LOOKUP, 32'd400, 8'hFF, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_HIT, 8'hFF, 8'hFF, 32'hFFFF_FFFF}},
        // lookup passes an expired match and clears it
        '{'{rte_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 8'd7, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_MISS, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_ADD, 32'd0, 8'd0, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_INSERTED, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_INVALIDATE, 32'd0, 8'd0, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_INVALIDATED, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_INVALIDATE, 32'd0, 8'd0, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_MISS, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_ADD, 32'd10, 8'd1, 8'h5A, 8'hA5, 32'd5}, 1'b0, NO_RESP},
        '{'{rte_pkg::ACT_SWEEP, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_SWEPT, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_LOOKUP, 32'd20, 8'd1, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_MISS, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_ADD, 32'd10, 8'd3, 8'h0F, 8'd3, 32'hFFFF_FFFF}, 1'b0, NO_RESP},
        // invalidate takes an expired entry too
        '{'{rte_pkg::ACT_INVALIDATE, 32'hFFFF_FFFF, 8'd3, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_INVALIDATED, 8'd0, 8'd0, 32'd0}},
        '{'{rte_pkg::ACT_LOOKUP, 32'd20, 8'hFF, 8'd0, 8'd0, 32'd0}, 1'b1,
          '{rte_pkg::ST_MISS, 8'd0, 8'd0, 32'd0}}
    };

    phase_t phases [7] = '{
        '{1'b0, 32'd30000,      32'd1000,      24, 5,  250},
        '{1'b1, 32'd100,        32'd5000,      6,  10, 300},
        '{1'b1, 32'd0,          32'd9000,      4,  3,  150},
        '{1'b1, 32'hFFFF_FFFF,  32'd0,         4,  1,  150},
        '{1'b1, 32'd0,          32'd0,         12, 0,  250},
        '{1'b1, 32'd500,        32'hFFFF_F000, 8,  50, 300},
        '{1'b1, 32'd60,         32'd20000,     16, 4,  500}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    route_table_engine_core #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .now           (now),
        .dest_node     (dest_node),
        .via_node      (via_node),
        .hops          (hops),
        .dest_seq      (dest_seq),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .route_next_hop(route_next_hop),
        .route_hops    (route_hops),
        .route_seq     (route_seq)
    );

    // First live slot for d; expired matches passed on the way are dropped.
    function automatic int scan_live(logic [7:0] d, logic [31:0] t);
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (tbl_used[i] && tbl_entry[i].dest == d)
            begin
                if (tbl_entry[i].expiry > t)
                    return i;
                tbl_used[i] = 1'b0;
            end
        end
        return -1;
    endfunction

    function automatic route_resp_t predict_route(route_req_t r);
        route_resp_t res;
        int          k;
        int          i;
        logic [31:0] gap;
        res = NO_RESP;
        res.status = rte_pkg::ST_MISS;
        case (r.action)
            rte_pkg::ACT_LOOKUP:
            begin
                k = scan_live(r.dest, r.now);
                if (k >= 0)
                begin
                    res.status = rte_pkg::ST_HIT;
                    res.nhop   = tbl_entry[k].nhop;
                    res.hops   = tbl_entry[k].hops;
                    res.seq    = tbl_entry[k].seq;
                end
            end
            rte_pkg::ACT_ADD:
            begin
                k = scan_live(r.dest, r.now);
                if (k >= 0)
                begin
                    // rollover-aware sequence compare
                    gap = r.seq - tbl_entry[k].seq;
                    if ((gap != 0 && gap < 32'h8000_0000) ||
                        (gap == 0 && r.hops < tbl_entry[k].hops))
                    begin
                        tbl_entry[k].nhop   = r.via;
                        tbl_entry[k].hops   = r.hops;
                        tbl_entry[k].seq    = r.seq;
                        tbl_entry[k].expiry = r.now + lifetime_m;
                        res.status = rte_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        res.status = rte_pkg::ST_UNCHANGED;
                    end
                end
                else
                begin
                    res.status = rte_pkg::ST_FULL;
                    for (i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (!tbl_used[i])
                        begin
                            tbl_used[i]         = 1'b1;
                            tbl_entry[i].dest   = r.dest;
                            tbl_entry[i].nhop   = r.via;
                            tbl_entry[i].hops   = r.hops;
                            tbl_entry[i].seq    = r.seq;
                            tbl_entry[i].expiry = r.now + lifetime_m;
                            res.status = rte_pkg::ST_INSERTED;
                            break;
                        end
                    end
                end
            end
            rte_pkg::ACT_REFRESH:
            begin
                k = scan_live(r.dest, r.now);
                if (k >= 0)
                begin
                    tbl_entry[k].expiry = r.now + lifetime_m;
                    res.status = rte_pkg::ST_REFRESHED;
                end
            end
            rte_pkg::ACT_INVALIDATE:
            begin
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (tbl_used[i] && tbl_entry[i].dest == r.dest)
                    begin
                        tbl_used[i] = 1'b0;
                        res.status = rte_pkg::ST_INVALIDATED;
                        break;
                    end
                end
            end
            rte_pkg::ACT_SWEEP:
            begin
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (tbl_used[i] && tbl_entry[i].expiry <= r.now)
                        tbl_used[i] = 1'b0;
                end
                res.status = rte_pkg::ST_SWEPT;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Mostly well-formed traffic on a small destination pool, some pure noise.
    function automatic route_req_t make_request(int pool, int step, logic [7:0] base);
        route_req_t r;
        int         pick;
        int         w;
        int         s;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            r.action = 3'($urandom_range(0, 7));
            r.now    = $urandom();
            r.dest   = 8'($urandom());
            r.via    = 8'($urandom());
            r.hops   = 8'($urandom());
            r.seq    = $urandom();
            return r;
        end
        tick   = (step == 0) ? $urandom() : tick + $urandom_range(0, step);
        r.now  = tick;
        r.dest = base + 8'($urandom_range(0, pool - 1));
        r.via  = 8'($urandom());
        r.hops = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 6));
        w = $urandom_range(0, 99);
        if (w < 36)
            r.action = rte_pkg::ACT_ADD;
        else if (w < 66)
            r.action = rte_pkg::ACT_LOOKUP;
        else if (w < 78)
            r.action = rte_pkg::ACT_REFRESH;
        else if (w < 88)
            r.action = rte_pkg::ACT_INVALIDATE;
        else if (w < 95)
            r.action = rte_pkg::ACT_SWEEP;
        else
            r.action = 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
        s = $urandom_range(0, 9);
        if (s == 0)
            r.seq = seq_hint[r.dest] + 32'h8000_0000;
        else if (s == 1)
            r.seq = seq_hint[r.dest] + 32'h7FFF_FFFF;
        else if (s == 2)
            r.seq = $urandom();
        else
            r.seq = seq_hint[r.dest] + 32'($urandom_range(0, 4)) - 32'd2;
        if (r.action == rte_pkg::ACT_ADD)
            seq_hint[r.dest] = r.seq;
        return r;
    endfunction

    task automatic send_request(input route_req_t r, input logic typed,
                                input route_resp_t typed_resp);
        route_resp_t pred;
        in_valid  <= 1'b1;
        action    <= r.action;
        now       <= r.now;
        dest_node <= r.dest;
        via_node  <= r.via;
        hops      <= r.hops;
        dest_seq  <= r.seq;
        do
            @(posedge clk);
        while (!in_ready);
        pred = predict_route(r);
        route_answers_q.push_back(typed ? typed_resp : pred);
    endtask

    task automatic pause_sender();
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // only with the table engine idle
    task automatic set_lifetime(input logic [31:0] v);
        in_valid <= 1'b0;
        while (route_answers_q.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        lifetime_m = v;
    endtask

    initial
    begin
        int          n;
        int          p;
        int          sent;
        int          total;
        logic [7:0]  base;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = rte_pkg::ACT_LOOKUP;
        now       = '0;
        dest_node = '0;
        via_node  = '0;
        hops      = '0;
        dest_seq  = '0;
        lifetime_m = rte_pkg::DEF_LIFETIME;
        for (n = 0; n < TABLE_DEPTH; n++)
        begin
            tbl_used[n]  = 1'b0;
            tbl_entry[n] = '0;
        end
        for (n = 0; n < 256; n++)
            seq_hint[n] = $urandom();
        phases[4].life = $urandom();
        total = 0;
        for (p = 0; p < $size(phases); p++)
            total += phases[p].count;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < $size(dir_rows); n++)
        begin
            pause_sender();
            send_request(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].resp);
        end

        sent = 0;
        for (p = 0; p < $size(phases); p++)
        begin
            if (phases[p].wr)
                set_lifetime(phases[p].life);
            tick = phases[p].start_tick;
            base = $urandom();
            for (n = 0; n < phases[p].count; n++)
            begin
                if (sent >= total - CALM_ITEMS)
                    calm = 1'b1;
                pause_sender();
                send_request(make_request(phases[p].pool, phases[p].step, base), 1'b0, NO_RESP);
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (route_answers_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side back-pressure in random bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_resp = '{status, route_next_hop, route_hops, route_seq};
            if (route_answers_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT)
                    $display("%0t: unexpected item status=%0d hop=%0d hops=%0d seq=%h",
                             $realtime, got_resp.status, got_resp.nhop,
                             got_resp.hops, got_resp.seq);
            end
            else
            begin
                want_resp = route_answers_q.pop_front();
                if (got_resp !== want_resp)
                begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display({"%0t: mismatch exp status=%0d hop=%0d hops=%0d seq=%h",
                                  " / got status=%0d hop=%0d hops=%0d seq=%h"},
                                 $realtime, want_resp.status, want_resp.nhop,
                                 want_resp.hops, want_resp.seq, got_resp.status,
                                 got_resp.nhop, got_resp.hops, got_resp.seq);
                end
            end
        end
    end

    // watchdog: no handshake on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
